>>> sv/hbs_pkg.sv
// Shared types, codes and constants for the heater burner sequencer.
// No dependencies; used by the interfaces, the step logic and the top level.
`default_nettype none

package hbs_pkg;

  localparam int unsigned OpW      = 3;
  localparam int unsigned ValW     = 8;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [OpW-1:0] OP_TICK    = 3'd0;
  localparam logic [OpW-1:0] OP_SET_ON  = 3'd1;
  localparam logic [OpW-1:0] OP_SET_BRN = 3'd2;
  localparam logic [OpW-1:0] OP_FAN_LVL = 3'd3;
  localparam logic [OpW-1:0] OP_HEAT_LVL = 3'd4;
  localparam logic [OpW-1:0] OP_TAGS    = 3'd5;

  localparam logic [PhaseW-1:0] PH_INIT     = 3'd0;
  localparam logic [PhaseW-1:0] PH_STARTING = 3'd1;
  localparam logic [PhaseW-1:0] PH_RUNNING  = 3'd2;
  localparam logic [PhaseW-1:0] PH_STOPPING = 3'd3;
  localparam logic [PhaseW-1:0] PH_STOPPED  = 3'd4;
  localparam logic [PhaseW-1:0] PH_TAGS     = 3'd5;

  localparam logic [CfgIdxW-1:0] CFG_PREPUMP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIVIDE  = 2'd1;

  localparam logic [7:0] PREPUMP_RST = 8'd5;
  localparam logic [3:0] DIVIDE_RST  = 4'd10;
  localparam logic [7:0] LEVEL_RST   = 8'd5;
  localparam logic [7:0] DUTY_MAX    = 8'd255;
  localparam logic [7:0] DUTY_BASE   = 8'd100;
  localparam logic [7:0] DUTY_STEP   = 8'd15;
  localparam logic [7:0] DUTY_IGNITE = 8'd250;
  localparam logic [7:0] PUMP_STEP   = 8'd25;
  localparam logic [7:0] LEVEL_MAX   = 8'd10;
  localparam logic [7:0] LEVEL_IGN   = 8'd9;
  localparam logic [7:0] LEVEL_RUN   = 8'd6;
  localparam logic [4:0] TAG_LAST    = 5'd14;
  localparam logic [4:0] TAG_RETURN  = 5'd16;
  localparam logic [4:0] TAG_STEP_MAX = 5'd31;

  typedef struct packed {
    logic [PhaseW-1:0] cur_phase;
    logic [PhaseW-1:0] next_phase;
    logic [PhaseW-1:0] resume_phase;
    logic              locked;
    logic [3:0]        tick_count;
    logic [7:0]        prepump_left;
    logic [4:0]        tag_step;
    logic              on_flag;
    logic              burning_flag;
    logic [7:0]        fan_request;
    logic              fan_pending;
    logic [7:0]        fan_level;
    logic [7:0]        heat_request;
    logic              heat_pending;
    logic [3:0]        heat_level;
    logic [7:0]        fan_pwm;
    logic [7:0]        heat_pwm;
    logic              glow_on;
    logic              pump_on;
    logic [7:0]        pump_rate;
  } hbs_state_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              phase_changed;
    logic [7:0]        fan_duty;
    logic [7:0]        heat_duty;
    logic              glow_plug;
    logic              pump_running;
    logic [7:0]        pump_speed;
    logic [7:0]        fan_status;
    logic [3:0]        heat_status;
    logic              tag_valid;
    logic [2:0]        tag_id;
  } hbs_result_t;

  function automatic logic [7:0] level_duty(input logic [7:0] lvl);
    logic [7:0] prod;
    prod = {4'b0000, lvl[3:0]} * DUTY_STEP;
    if (lvl > LEVEL_MAX) begin
      return DUTY_MAX;
    end
    return DUTY_BASE + prod;
  endfunction

endpackage

`default_nettype wire

>>> sv/hbs_if.sv
// Valid/ready channel interfaces for event input and status output.
// Depends on hbs_pkg for field widths.
`default_nettype none

interface hbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [hbs_pkg::OpW-1:0]     opcode;
  logic [hbs_pkg::ValW-1:0]    value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface hbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [hbs_pkg::PhaseW-1:0]  phase;
  logic                        phase_changed;
  logic [7:0]                  fan_duty;
  logic [7:0]                  heat_duty;
  logic                        glow_plug;
  logic                        pump_running;
  logic [7:0]                  pump_speed;
  logic [7:0]                  fan_status;
  logic [3:0]                  heat_status;
  logic                        tag_valid;
  logic [2:0]                  tag_id;

  modport source (output valid, output phase, output phase_changed, output fan_duty,
                  output heat_duty, output glow_plug, output pump_running,
                  output pump_speed, output fan_status, output heat_status,
                  output tag_valid, output tag_id, input ready);
  modport sink   (input valid, input phase, input phase_changed, input fan_duty,
                  input heat_duty, input glow_plug, input pump_running,
                  input pump_speed, input fan_status, input heat_status,
                  input tag_valid, input tag_id, output ready);
endinterface

`default_nettype wire

>>> sv/hbs_step.sv
// Combinational event step: next sequencer state and the status result.
// Depends on hbs_pkg.
`default_nettype none

module hbs_step (
  input  hbs_pkg::hbs_state_t        state_i,
  input  logic [3:0]                 tick_divide_i,
  input  logic [hbs_pkg::OpW-1:0]    opcode_i,
  input  logic [hbs_pkg::ValW-1:0]   value_i,
  output hbs_pkg::hbs_state_t        state_o,
  output hbs_pkg::hbs_result_t       result_o
);

  hbs_pkg::hbs_state_t s;
  logic                changed;
  logic                tv;
  logic [2:0]          tid;
  logic [3:0]          tick_inc;
  logic [7:0]          lvl;

  always_comb begin
    s        = state_i;
    changed  = 1'b0;
    tv       = 1'b0;
    tid      = 3'd0;
    tick_inc = state_i.tick_count + 4'd1;
    lvl      = state_i.heat_request;
    unique case (opcode_i)
      hbs_pkg::OP_TICK: begin
        s.tick_count = tick_inc;
        if (tick_inc >= tick_divide_i) begin
          s.tick_count = 4'd0;
          if (!state_i.locked) begin
            if (state_i.next_phase != state_i.cur_phase) begin
              s.cur_phase = state_i.next_phase;
              changed     = 1'b1;
            end
            case (s.cur_phase)
              hbs_pkg::PH_INIT: begin
                if (state_i.prepump_left != 8'd0) begin
                  s.prepump_left = state_i.prepump_left - 8'd1;
                end
                if (s.prepump_left == 8'd0) begin
                  s.heat_pwm     = hbs_pkg::DUTY_IGNITE;
                  s.heat_level   = hbs_pkg::LEVEL_IGN[3:0];
                  s.heat_request = hbs_pkg::LEVEL_IGN;
                  s.glow_on      = 1'b1;
                  s.next_phase   = hbs_pkg::PH_STARTING;
                end
              end
              hbs_pkg::PH_STARTING: begin
                if (state_i.burning_flag) begin
                  s.on_flag      = 1'b1;
                  s.heat_level   = hbs_pkg::LEVEL_RUN[3:0];
                  s.heat_request = hbs_pkg::LEVEL_RUN;
                  s.heat_pending = 1'b1;
                  s.fan_level    = hbs_pkg::LEVEL_RUN;
                  s.fan_request  = hbs_pkg::LEVEL_RUN;
                  s.fan_pending  = 1'b1;
                  s.glow_on      = 1'b0;
                  s.next_phase   = hbs_pkg::PH_RUNNING;
                end
              end
              hbs_pkg::PH_RUNNING: begin
                if (state_i.fan_pending) begin
                  s.fan_level   = state_i.fan_request;
                  s.fan_pwm     = hbs_pkg::level_duty(state_i.fan_request);
                  s.fan_pending = 1'b0;
                end
                if (state_i.heat_pending) begin
                  s.heat_pwm     = hbs_pkg::level_duty(lvl);
                  s.heat_level   = (lvl > hbs_pkg::LEVEL_MAX) ?
                                   hbs_pkg::LEVEL_MAX[3:0] : lvl[3:0];
                  s.heat_pending = 1'b0;
                  s.pump_rate    = {4'b0000, s.heat_level} * hbs_pkg::PUMP_STEP;
                end
                if (!state_i.on_flag) begin
                  s.pump_on    = 1'b0;
                  s.next_phase = hbs_pkg::PH_STOPPING;
                end
              end
              hbs_pkg::PH_STOPPING: begin
                if (!state_i.burning_flag) begin
                  s.fan_pwm    = 8'd0;
                  s.heat_pwm   = 8'd0;
                  s.next_phase = hbs_pkg::PH_STOPPED;
                end
              end
              hbs_pkg::PH_TAGS: begin
                if (state_i.tag_step <= hbs_pkg::TAG_LAST && !state_i.tag_step[0]) begin
                  tv  = 1'b1;
                  tid = state_i.tag_step[3:1];
                end else if (state_i.tag_step > hbs_pkg::TAG_RETURN) begin
                  s.next_phase = state_i.resume_phase;
                end
                if (state_i.tag_step < hbs_pkg::TAG_STEP_MAX) begin
                  s.tag_step = state_i.tag_step + 5'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      hbs_pkg::OP_SET_ON:  s.on_flag      = (value_i != 8'd0);
      hbs_pkg::OP_SET_BRN: s.burning_flag = (value_i != 8'd0);
      hbs_pkg::OP_FAN_LVL: begin
        s.fan_request = value_i;
        s.fan_pending = 1'b1;
      end
      hbs_pkg::OP_HEAT_LVL: begin
        s.heat_request = value_i;
        s.heat_pending = 1'b1;
      end
      hbs_pkg::OP_TAGS: begin
        s.resume_phase = state_i.cur_phase;
        s.tag_step     = 5'd0;
        s.next_phase   = hbs_pkg::PH_TAGS;
        s.locked       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign state_o = s;

  always_comb begin
    result_o.phase         = s.cur_phase;
    result_o.phase_changed = changed;
    result_o.fan_duty      = s.fan_pwm;
    result_o.heat_duty     = s.heat_pwm;
    result_o.glow_plug     = s.glow_on;
    result_o.pump_running  = s.pump_on;
    result_o.pump_speed    = s.pump_rate;
    result_o.fan_status    = s.fan_level;
    result_o.heat_status   = s.heat_level;
    result_o.tag_valid     = tv;
    result_o.tag_id        = tid;
  end

endmodule

`default_nettype wire

>>> sv/heater_burner_sequencer_unit.sv
// Heater burner sequencer top level: state and config registers, output register.
// Depends on hbs_pkg, hbs_if.sv (hbs_in_if, hbs_out_if) and hbs_step.
//
// Usage: events enter on in_i (opcode, value) as valid/ready transfers; each
// event yields exactly one status item on out_o, showing the state after it.
// Configuration (prepump_ticks at index 0, tick_divide at index 1) is written
// through cfg_we_i / cfg_index_i / cfg_data_i while no event is in flight;
// writing prepump_ticks also reloads the pre-pump countdown.
// Latency: the status item is valid in the cycle after the input transfer.
// Throughput: one event per cycle unless stalled; the step is one pass of
// combinational logic from the state registers into the output register.
// Stall: in_i.ready drops only while the output register holds an untaken
// item and out_o.ready is low; the held item stays stable until taken.
// Reset: asynchronous, active low; returns phase to init, locked until the
// first tag request, config to prepump 5 and divide 10, output empty.
`default_nettype none

module heater_burner_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hbs_pkg::CfgDataW-1:0]  cfg_data_i,
  hbs_in_if.sink                        in_i,
  hbs_out_if.source                     out_o
);

  hbs_pkg::hbs_state_t  state_q, state_d, step_state;
  hbs_pkg::hbs_result_t result_q, step_result;
  logic                 out_valid_q;
  logic [3:0]           tick_divide_q;
  logic                 in_xfer;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  hbs_step u_step (
    .state_i       (state_q),
    .tick_divide_i (tick_divide_q),
    .opcode_i      (in_i.opcode),
    .value_i       (in_i.value),
    .state_o       (step_state),
    .result_o      (step_result)
  );

  // a prepump_ticks write lands directly in the countdown
  always_comb begin
    state_d = in_xfer ? step_state : state_q;
    if (cfg_we_i && cfg_index_i == hbs_pkg::CFG_PREPUMP) begin
      state_d.prepump_left = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_divide_q <= hbs_pkg::DIVIDE_RST;
    end else if (cfg_we_i && cfg_index_i == hbs_pkg::CFG_DIVIDE) begin
      tick_divide_q <= cfg_data_i[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cur_phase    <= hbs_pkg::PH_INIT;
      state_q.next_phase   <= hbs_pkg::PH_INIT;
      state_q.resume_phase <= hbs_pkg::PH_INIT;
      state_q.locked       <= 1'b1;
      state_q.tick_count   <= 4'd0;
      state_q.prepump_left <= hbs_pkg::PREPUMP_RST;
      state_q.tag_step     <= 5'd0;
      state_q.on_flag      <= 1'b0;
      state_q.burning_flag <= 1'b0;
      state_q.fan_request  <= 8'd0;
      state_q.fan_pending  <= 1'b0;
      state_q.fan_level    <= hbs_pkg::LEVEL_RST;
      state_q.heat_request <= 8'd0;
      state_q.heat_pending <= 1'b0;
      state_q.heat_level   <= hbs_pkg::LEVEL_RST[3:0];
      state_q.fan_pwm      <= 8'd0;
      state_q.heat_pwm     <= 8'd0;
      state_q.glow_on      <= 1'b0;
      state_q.pump_on      <= 1'b1;
      state_q.pump_rate    <= 8'd0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= step_result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.phase         = result_q.phase;
  assign out_o.phase_changed = result_q.phase_changed;
  assign out_o.fan_duty      = result_q.fan_duty;
  assign out_o.heat_duty     = result_q.heat_duty;
  assign out_o.glow_plug     = result_q.glow_plug;
  assign out_o.pump_running  = result_q.pump_running;
  assign out_o.pump_speed    = result_q.pump_speed;
  assign out_o.fan_status    = result_q.fan_status;
  assign out_o.heat_status   = result_q.heat_status;
  assign out_o.tag_valid     = result_q.tag_valid;
  assign out_o.tag_id        = result_q.tag_id;

  a_tag_in_tag_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.tag_valid |-> result_q.phase == hbs_pkg::PH_TAGS)
    else $error("tag announced outside tag phase");

  a_tag_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_q.tag_valid |-> result_q.tag_id == 3'd0)
    else $error("tag id set without tag");

  a_heat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.heat_level <= hbs_pkg::LEVEL_MAX[3:0])
    else $error("heat level above clamp");

  a_locked_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.locked |-> state_q.cur_phase == hbs_pkg::PH_INIT)
    else $error("phase moved while locked");

endmodule

`default_nettype wire
